// ----- hw/rtl/gbnrx_pkg.sv -----
// Shared types and constants for the go-back-N receiver core.
// Transaction payload structs, result codes and frame layout constants.
// No dependencies.
`default_nettype none

package gbnrx_pkg;

  localparam int POS_W                 = 5;
  localparam int SUM_W                 = 16;
  localparam int PAYLOAD_BYTES_DEFAULT = 20;
  localparam int HEADER_BYTES          = 4;

  localparam logic [7:0]       DASH_CHAR      = 8'h2D;
  localparam logic [SUM_W-1:0] SEQ_STEP_RESET = 16'd20;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REPEAT = 2'd1,
    KIND_FINISH = 2'd2
  } result_kind_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_first;
  } in_item_t;

  typedef struct packed {
    logic [15:0]  ack_number;
    result_kind_t result_kind;
  } out_item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/gbnrx_csum.sv -----
// Payload checksum step: 16-bit end-around-carry byte add that freezes at the first zero byte.
// Depends on gbnrx_pkg for the sum width.
`default_nettype none

module gbnrx_csum (
  input  wire logic [gbnrx_pkg::SUM_W-1:0] sum,
  input  wire logic                        zero_seen,
  input  wire logic [7:0]                  frame_byte,
  output logic      [gbnrx_pkg::SUM_W-1:0] sum_next,
  output logic                             zero_seen_next
);
  import gbnrx_pkg::*;

  logic [SUM_W:0]   raw_sum;
  logic [SUM_W-1:0] folded_sum;

  // Fold the carry back into bit 0.
  assign raw_sum    = {1'b0, sum} + {{(SUM_W - 7){1'b0}}, frame_byte};
  assign folded_sum = raw_sum[SUM_W-1:0] + {{(SUM_W - 1){1'b0}}, raw_sum[SUM_W]};

  always_comb begin
    sum_next       = sum;
    zero_seen_next = zero_seen;
    if (!zero_seen) begin
      if (frame_byte == 8'd0) begin
        zero_seen_next = 1'b1;
      end else begin
        sum_next = folded_sum;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/go_back_n_receiver_checksum_core.sv -----
// Go-back-N receiver core with a ones-complement payload checksum check.
// A byte enters the input register; its result (if any) then loads the result register.
// Throughput: one byte per cycle; a held result under stall backs up and stalls the input.
// Reset: synchronous, active-high rst clears all frame and session state, sets seq_step to 20.
// Depends on gbnrx_pkg and gbnrx_csum.
`default_nettype none

module go_back_n_receiver_checksum_core #(
  parameter int PAYLOAD_BYTES = gbnrx_pkg::PAYLOAD_BYTES_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration: seq_step register
  input  wire logic                 cfg_write_en,
  input  wire logic [15:0]          cfg_write_data,
  // byte input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire gbnrx_pkg::in_item_t  in_data,
  // ACK result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output gbnrx_pkg::out_item_t      out_data
);
  import gbnrx_pkg::*;

  // Position of the last byte of a frame (header plus payload, minus one).
  localparam logic [POS_W-1:0] FRAME_LAST = POS_W'(HEADER_BYTES + PAYLOAD_BYTES - 1);

  // Configuration register.
  logic [15:0] seq_step;

  // Session state.
  logic [15:0] expected_seq, expected_seq_next;
  logic [15:0] last_acked, last_acked_next;
  logic        halted, halted_next;

  // Frame state.
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [SUM_W-1:0] running_sum, running_sum_next;
  logic [15:0]      received_seq, received_seq_next;
  logic [15:0]      received_check, received_check_next;
  logic             zero_seen, zero_seen_next;
  logic [1:0]       dash_prefix, dash_prefix_next;

  // Input register.
  logic     in_q_valid;
  in_item_t in_q;

  // Frame state as seen by the byte in the input register: a first-byte
  // marker drops any partial frame before the byte is applied.
  logic [POS_W-1:0] pos;
  logic [SUM_W-1:0] sum_eff;
  logic [15:0]      seq_eff;
  logic [15:0]      check_eff;
  logic             zero_eff;
  logic [1:0]       dash_eff;

  logic [SUM_W-1:0] sum_add;
  logic             zero_add;

  logic      process;
  logic      load_result;
  out_item_t result_next;
  logic      frame_done;
  logic      is_dash;

  // Process the held byte whenever the result register can take a result.
  assign process  = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !process;

  assign pos       = in_q.frame_first ? '0 : byte_position;
  assign sum_eff   = in_q.frame_first ? '0 : running_sum;
  assign seq_eff   = in_q.frame_first ? '0 : received_seq;
  assign check_eff = in_q.frame_first ? '0 : received_check;
  assign zero_eff  = in_q.frame_first ? 1'b0 : zero_seen;
  assign dash_eff  = in_q.frame_first ? 2'd0 : dash_prefix;
  assign is_dash   = (in_q.frame_byte == DASH_CHAR);

  gbnrx_csum u_csum (
    .sum            (sum_eff),
    .zero_seen      (zero_eff),
    .frame_byte     (in_q.frame_byte),
    .sum_next       (sum_add),
    .zero_seen_next (zero_add)
  );

  always_comb begin
    expected_seq_next   = expected_seq;
    last_acked_next     = last_acked;
    halted_next         = halted;
    byte_position_next  = byte_position;
    running_sum_next    = running_sum;
    received_seq_next   = received_seq;
    received_check_next = received_check;
    zero_seen_next      = zero_seen;
    dash_prefix_next    = dash_prefix;
    load_result         = 1'b0;
    result_next         = out_data;
    frame_done          = 1'b0;

    // Halted: drain bytes with no effect.
    if (process && !halted) begin
      running_sum_next    = sum_eff;
      received_seq_next   = seq_eff;
      received_check_next = check_eff;
      zero_seen_next      = zero_eff;
      dash_prefix_next    = dash_eff;

      unique case (pos)
        POS_W'(0): begin
          received_seq_next = {8'd0, in_q.frame_byte};
          dash_prefix_next  = is_dash ? 2'd1 : 2'd0;
        end
        POS_W'(1): begin
          received_seq_next = {in_q.frame_byte, seq_eff[7:0]};
          dash_prefix_next  = (dash_eff == 2'd1 && is_dash) ? 2'd2 : 2'd0;
        end
        POS_W'(2): begin
          dash_prefix_next    = 2'd0;
          received_check_next = {8'd0, in_q.frame_byte};
        end
        POS_W'(3): begin
          received_check_next = {in_q.frame_byte, check_eff[7:0]};
        end
        default: begin
          running_sum_next = sum_add;
          zero_seen_next   = zero_add;
          frame_done       = (pos >= FRAME_LAST);
        end
      endcase

      if (pos == POS_W'(2) && dash_eff == 2'd2 && is_dash) begin
        // Three dashes: finish the session and halt.
        halted_next             = 1'b1;
        load_result             = 1'b1;
        result_next.ack_number  = '0;
        result_next.result_kind = KIND_FINISH;
      end else if (frame_done) begin
        load_result = 1'b1;
        if (~sum_add == check_eff && seq_eff == expected_seq) begin
          result_next.ack_number  = seq_eff;
          result_next.result_kind = KIND_ACCEPT;
          last_acked_next         = seq_eff;
          expected_seq_next       = expected_seq + seq_step;
        end else begin
          result_next.ack_number  = last_acked;
          result_next.result_kind = KIND_REPEAT;
        end
        // Start a fresh frame on the next byte.
        byte_position_next  = '0;
        running_sum_next    = '0;
        received_seq_next   = '0;
        received_check_next = '0;
        zero_seen_next      = 1'b0;
        dash_prefix_next    = 2'd0;
      end else begin
        byte_position_next = pos + POS_W'(1);
      end
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_step       <= SEQ_STEP_RESET;
      expected_seq   <= '0;
      last_acked     <= '0;
      halted         <= 1'b0;
      byte_position  <= '0;
      running_sum    <= '0;
      received_seq   <= '0;
      received_check <= '0;
      zero_seen      <= 1'b0;
      dash_prefix    <= 2'd0;
      in_q_valid     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        seq_step <= cfg_write_data;
      end
      expected_seq   <= expected_seq_next;
      last_acked     <= last_acked_next;
      halted         <= halted_next;
      byte_position  <= byte_position_next;
      running_sum    <= running_sum_next;
      received_seq   <= received_seq_next;
      received_check <= received_check_next;
      zero_seen      <= zero_seen_next;
      dash_prefix    <= dash_prefix_next;
      // Advance the input register whenever it is empty or being drained.
      if (!in_stall) begin
        in_q_valid <= in_valid;
      end
      // Load a new result, or drop the old one once taken.
      if (load_result) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
    if (load_result) begin
      out_data <= result_next;
    end
  end

  // Once halted, no new result transaction is ever produced.
  a_halted_silent : assert property (@(posedge clk) disable iff (rst)
    halted && (!out_valid || !out_stall) |=> !out_valid)
    else $error("result produced after halt");

  // A finish result means the session is halted and acknowledges zero.
  a_finish_halts : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind == KIND_FINISH |-> halted && out_data.ack_number == '0)
    else $error("finish result without halt");

  // A repeat result carries the last recorded ACK.
  a_repeat_last : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind == KIND_REPEAT |-> out_data.ack_number == last_acked)
    else $error("repeat ACK differs from last recorded ACK");

endmodule

`default_nettype wire
